// ===== rtl/tspq_pkg.sv =====
// tspq_pkg: shared types, constants and helpers for the three-class queue.
// No dependencies; used by tspq_idmem and three_class_stable_priority_queue_core.
package tspq_pkg;

  localparam int Capacity   = 64;
  localparam int NumClasses = 3;
  localparam int MemDepth   = NumClasses * Capacity;

  localparam int PTR_W  = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int CNT_W  = $clog2(Capacity + 1);
  localparam int ADDR_W = $clog2(MemDepth);
  localparam int ID_W   = 16;
  localparam int CLS_W  = 2;
  localparam int OCC_W  = 7;

  localparam logic [CLS_W-1:0] CLASS_HIGH = 2'd0;
  localparam logic [CLS_W-1:0] CLASS_MID  = 2'd1;
  localparam logic [CLS_W-1:0] CLASS_LOW  = 2'd2;

  typedef enum logic {
    FUNC_ENQ = 1'b0,
    FUNC_DEQ = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_SERVED   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  // one write port, one read port per cycle
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ID_W-1:0]   wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(Capacity - 1)) ? '0 : p + 1'b1;
  endfunction

  // start of a class region in the id store
  function automatic logic [ADDR_W-1:0] class_base(input logic [CLS_W-1:0] cls);
    case (cls)
      CLASS_MID: return ADDR_W'(Capacity);
      CLASS_LOW: return ADDR_W'(2 * Capacity);
      default:   return '0;
    endcase
  endfunction

  function automatic logic [OCC_W-1:0] occ_word(input logic [CNT_W-1:0] cnt);
    return OCC_W'(32'(cnt));
  endfunction

endpackage

// ===== rtl/tspq_idmem.sv =====
// tspq_idmem: id store, one region of Capacity slots per class.
// Synchronous write, registered read. Uses tspq_pkg.
module tspq_idmem (
  input  logic                           clk,
  input  tspq_pkg::mem_req_t             req,
  output logic [tspq_pkg::ID_W-1:0]      rd_data
);

  logic [tspq_pkg::ID_W-1:0] mem [tspq_pkg::MemDepth];
  logic [tspq_pkg::ID_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/three_class_stable_priority_queue_core.sv =====
// three_class_stable_priority_queue_core: top level of the three-class queue.
// Uses tspq_pkg and tspq_idmem (id store).
//
// Usage:
//   Input channel (in_valid/in_ready) carries one word per operation:
//   in_func selects enqueue or dequeue, in_entry_id and in_entry_class are
//   the entry for an enqueue (class code 3 is taken as the lowest class).
//   Result channel (out_valid/out_ready) returns exactly one word per
//   operation: status (enqueued, served, empty, full), the served id and
//   class (zero unless served) and the occupancy after the operation.
// Flow:
//   Enqueue, failed enqueue and empty dequeue: result word registered on
//   acceptance; one such operation per cycle while out_ready is high.
//   Successful dequeue: the id store is read first through its registered
//   read port; the next word is taken once the read data is in the output
//   register.
// Reset (rst_n low, synchronous): all class FIFOs empty, no result pending.
//   Id store contents are not cleared; a slot is read only after a write.
// Stall: the result sits in the output register until out_ready; in_ready
//   is high in S_IDLE while the output register is free or being emptied.
module three_class_stable_priority_queue_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_func,
  input  logic [tspq_pkg::ID_W-1:0]    in_entry_id,
  input  logic [tspq_pkg::CLS_W-1:0]   in_entry_class,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_status,
  output logic [tspq_pkg::ID_W-1:0]    out_served_id,
  output logic [tspq_pkg::CLS_W-1:0]   out_served_class,
  output logic [tspq_pkg::OCC_W-1:0]   out_occupancy
);

  // FSM
  tspq_pkg::state_t state_r, state_nxt;
  logic rd_load;  // read data lands in output register this cycle

  // FIFO bookkeeping, one entry per class
  logic [tspq_pkg::PTR_W-1:0] head_r [tspq_pkg::NumClasses];
  logic [tspq_pkg::PTR_W-1:0] head_nxt [tspq_pkg::NumClasses];
  logic [tspq_pkg::PTR_W-1:0] tail_r [tspq_pkg::NumClasses];
  logic [tspq_pkg::PTR_W-1:0] tail_nxt [tspq_pkg::NumClasses];
  logic [tspq_pkg::CNT_W-1:0] cnt_r [tspq_pkg::NumClasses];
  logic [tspq_pkg::CNT_W-1:0] cnt_nxt [tspq_pkg::NumClasses];
  logic [tspq_pkg::CNT_W-1:0] total_r, total_nxt;

  // pending served word while the id store read is in flight
  logic [tspq_pkg::CLS_W-1:0] pend_cls_r, pend_cls_nxt;
  logic [tspq_pkg::OCC_W-1:0] pend_occ_r, pend_occ_nxt;

  // output register
  logic                       out_valid_r, out_valid_nxt;
  tspq_pkg::status_t          out_status_r, out_status_nxt;
  logic [tspq_pkg::ID_W-1:0]  out_id_r, out_id_nxt;
  logic [tspq_pkg::CLS_W-1:0] out_cls_r, out_cls_nxt;
  logic [tspq_pkg::OCC_W-1:0] out_occ_r, out_occ_nxt;

  logic                       acc;
  logic                       is_deq;
  logic                       is_full;
  logic                       nonempty;
  logic                       do_enq;
  logic                       do_deq;
  logic [tspq_pkg::CLS_W-1:0] enq_cls;
  logic [tspq_pkg::CLS_W-1:0] deq_cls;
  logic [tspq_pkg::ID_W-1:0]  rd_data;
  tspq_pkg::mem_req_t         mem_req;

  tspq_idmem u_idmem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // ---------------- FSM: next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tspq_pkg::S_IDLE: begin
        if (do_deq) begin
          state_nxt = tspq_pkg::S_READ;
        end
      end
      tspq_pkg::S_READ: begin
        state_nxt = tspq_pkg::S_IDLE;
      end
      default: begin
        state_nxt = tspq_pkg::S_IDLE;
      end
    endcase
  end

  // ---------------- FSM: outputs ----------------
  always_comb begin
    in_ready = 1'b0;
    rd_load  = 1'b0;
    case (state_r)
      tspq_pkg::S_IDLE: begin
        in_ready = !out_valid_r || out_ready;
      end
      tspq_pkg::S_READ: begin
        rd_load = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // ---------------- operation decode ----------------
  always_comb begin
    acc     = in_valid && in_ready;
    is_deq  = (in_func == tspq_pkg::FUNC_DEQ);
    is_full = (total_r >= tspq_pkg::CNT_W'(tspq_pkg::Capacity));
    // unused class code folds into the lowest class
    enq_cls = (in_entry_class > tspq_pkg::CLASS_LOW) ? tspq_pkg::CLASS_LOW : in_entry_class;

    // highest non-empty class wins
    nonempty = 1'b1;
    if (cnt_r[0] != '0) begin
      deq_cls = tspq_pkg::CLASS_HIGH;
    end else if (cnt_r[1] != '0) begin
      deq_cls = tspq_pkg::CLASS_MID;
    end else if (cnt_r[2] != '0) begin
      deq_cls = tspq_pkg::CLASS_LOW;
    end else begin
      deq_cls  = tspq_pkg::CLASS_HIGH;
      nonempty = 1'b0;
    end

    do_enq = acc && !is_deq && !is_full;
    do_deq = acc && is_deq && nonempty;
  end

  // ---------------- id store access ----------------
  always_comb begin
    mem_req.we    = do_enq;
    mem_req.waddr = tspq_pkg::class_base(enq_cls)
                    + tspq_pkg::ADDR_W'(tail_r[enq_cls]);
    mem_req.wdata = in_entry_id;
    mem_req.re    = do_deq;
    mem_req.raddr = tspq_pkg::class_base(deq_cls)
                    + tspq_pkg::ADDR_W'(head_r[deq_cls]);
  end

  // ---------------- pointer and count update ----------------
  always_comb begin
    for (int c = 0; c < tspq_pkg::NumClasses; c++) begin
      head_nxt[c] = head_r[c];
      tail_nxt[c] = tail_r[c];
      cnt_nxt[c]  = cnt_r[c];
      if (do_enq && (enq_cls == tspq_pkg::CLS_W'(c))) begin
        tail_nxt[c] = tspq_pkg::ptr_advance(tail_r[c]);
        cnt_nxt[c]  = cnt_r[c] + 1'b1;
      end
      if (do_deq && (deq_cls == tspq_pkg::CLS_W'(c))) begin
        head_nxt[c] = tspq_pkg::ptr_advance(head_r[c]);
        cnt_nxt[c]  = cnt_r[c] - 1'b1;
      end
    end
    total_nxt = total_r;
    if (do_enq) begin
      total_nxt = total_r + 1'b1;
    end else if (do_deq) begin
      total_nxt = total_r - 1'b1;
    end
  end

  // ---------------- result word ----------------
  always_comb begin
    pend_cls_nxt   = pend_cls_r;
    pend_occ_nxt   = pend_occ_r;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_cls_nxt    = out_cls_r;
    out_occ_nxt    = out_occ_r;
    out_valid_nxt  = out_valid_r && !out_ready;

    if (rd_load) begin
      // served word completes with the id store data
      out_valid_nxt  = 1'b1;
      out_status_nxt = tspq_pkg::ST_SERVED;
      out_id_nxt     = rd_data;
      out_cls_nxt    = pend_cls_r;
      out_occ_nxt    = pend_occ_r;
    end else if (do_deq) begin
      pend_cls_nxt = deq_cls;
      pend_occ_nxt = tspq_pkg::occ_word(total_nxt);
    end else if (acc) begin
      out_valid_nxt = 1'b1;
      out_id_nxt    = '0;
      out_cls_nxt   = '0;
      out_occ_nxt   = tspq_pkg::occ_word(total_nxt);
      if (is_deq) begin
        out_status_nxt = tspq_pkg::ST_EMPTY;
      end else if (is_full) begin
        out_status_nxt = tspq_pkg::ST_FULL;
      end else begin
        out_status_nxt = tspq_pkg::ST_ENQUEUED;
      end
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tspq_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      total_r     <= '0;
      for (int c = 0; c < tspq_pkg::NumClasses; c++) begin
        head_r[c] <= '0;
        tail_r[c] <= '0;
        cnt_r[c]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      total_r     <= total_nxt;
      for (int c = 0; c < tspq_pkg::NumClasses; c++) begin
        head_r[c] <= head_nxt[c];
        tail_r[c] <= tail_nxt[c];
        cnt_r[c]  <= cnt_nxt[c];
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    pend_cls_r   <= pend_cls_nxt;
    pend_occ_r   <= pend_occ_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_cls_r    <= out_cls_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_served_id    = out_id_r;
  assign out_served_class = out_cls_r;
  assign out_occupancy    = out_occ_r;

  // ---------------- assertions ----------------
  // total count tracks the per-class counts
  a_total_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(total_r) == 32'(cnt_r[0]) + 32'(cnt_r[1]) + 32'(cnt_r[2])))
    else $error("total count out of step with class counts");

  // never more entries than Capacity
  a_total_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(total_r) <= tspq_pkg::Capacity))
    else $error("total count above capacity");

  // read in flight only with a free output register
  a_read_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tspq_pkg::S_READ) |-> !out_valid_r)
    else $error("output register busy during id store read");

  // a successful dequeue is followed by its served word
  a_deq_served: assert property (@(posedge clk) disable iff (!rst_n)
    do_deq |=> ##1 (out_valid_r && (out_status_r == tspq_pkg::ST_SERVED)))
    else $error("served word missing after dequeue");

endmodule

// ===== bench/tb.sv =====
// tb: self-checking bench for three_class_stable_priority_queue_core.
// Needs tspq_pkg and the core RTL; a directed table first, then random traffic
// scored against an in-bench model of the three class FIFOs.
`timescale 1ns / 100ps

module tb;

  localparam int RANDOM_WORDS = 1036;
  localparam int CALM_WORDS   = 150;   // segments starting in this tail of the run have no idling
  localparam int DRAIN_CYCLES = 8;

  // one result word as the core reports it
  typedef struct packed {
    tspq_pkg::status_t          status;
    logic [tspq_pkg::ID_W-1:0]  id;
    logic [tspq_pkg::CLS_W-1:0] cls;
    logic [tspq_pkg::OCC_W-1:0] occ;
  } queue_word_t;

  // directed row; fixed set means the expected word is typed in, else predicted
  typedef struct packed {
    tspq_pkg::func_t            f;
    logic [tspq_pkg::ID_W-1:0]  id;
    logic [tspq_pkg::CLS_W-1:0] cls;
    logic                       fixed;
    queue_word_t                want;
  } stim_row_t;

  localparam queue_word_t NO_WORD = '0;

  localparam stim_row_t DIRECTED_ROWS [14] = '{
    // dequeue straight after reset: empty, nothing served
    '{tspq_pkg::FUNC_DEQ, 16'h0000, 2'd0, 1'b1,
      '{tspq_pkg::ST_EMPTY, 16'h0000, 2'd0, 7'd0}},
    // fill every class; id extremes, class three lands in the lowest class
    '{tspq_pkg::FUNC_ENQ, 16'hFFFF, tspq_pkg::CLASS_HIGH, 1'b1,
      '{tspq_pkg::ST_ENQUEUED, 16'h0000, 2'd0, 7'd1}},
    '{tspq_pkg::FUNC_ENQ, 16'h0000, tspq_pkg::CLASS_LOW, 1'b1,
      '{tspq_pkg::ST_ENQUEUED, 16'h0000, 2'd0, 7'd2}},
    '{tspq_pkg::FUNC_ENQ, 16'h1234, 2'd3, 1'b1,
      '{tspq_pkg::ST_ENQUEUED, 16'h0000, 2'd0, 7'd3}},
    '{tspq_pkg::FUNC_ENQ, 16'hA5A5, tspq_pkg::CLASS_MID, 1'b1,
      '{tspq_pkg::ST_ENQUEUED, 16'h0000, 2'd0, 7'd4}},
    '{tspq_pkg::FUNC_ENQ, 16'h5A5A, tspq_pkg::CLASS_HIGH, 1'b1,
      '{tspq_pkg::ST_ENQUEUED, 16'h0000, 2'd0, 7'd5}},
    // drain: class order, FIFO within a class; payload ignored on dequeue
    '{tspq_pkg::FUNC_DEQ, 16'hFFFF, 2'd3, 1'b0, NO_WORD},
    '{tspq_pkg::FUNC_DEQ, 16'h0000, 2'd0, 1'b0, NO_WORD},
    '{tspq_pkg::FUNC_DEQ, 16'h0000, 2'd0, 1'b0, NO_WORD},
    '{tspq_pkg::FUNC_DEQ, 16'h0000, 2'd0, 1'b0, NO_WORD},
    '{tspq_pkg::FUNC_DEQ, 16'h0000, 2'd0, 1'b0, NO_WORD},
    '{tspq_pkg::FUNC_DEQ, 16'h0000, 2'd0, 1'b1,
      '{tspq_pkg::ST_EMPTY, 16'h0000, 2'd0, 7'd0}},
    '{tspq_pkg::FUNC_ENQ, 16'h8001, tspq_pkg::CLASS_MID, 1'b0, NO_WORD},
    '{tspq_pkg::FUNC_DEQ, 16'h7FFE, 2'd2, 1'b0, NO_WORD}
  };

  logic                             clk;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_ready;
  logic                             in_func;
  logic [tspq_pkg::ID_W-1:0]        in_entry_id;
  logic [tspq_pkg::CLS_W-1:0]       in_entry_class;
  logic                             out_valid;
  logic                             out_ready;
  logic [1:0]                       out_status;
  logic [tspq_pkg::ID_W-1:0]        out_served_id;
  logic [tspq_pkg::CLS_W-1:0]       out_served_class;
  logic [tspq_pkg::OCC_W-1:0]       out_occupancy;

  // model of the queue: one circular buffer per class plus a total
  logic [tspq_pkg::ID_W-1:0] held_ids [tspq_pkg::NumClasses][tspq_pkg::Capacity];
  int                  head_slot [tspq_pkg::NumClasses];
  int                  tail_slot [tspq_pkg::NumClasses];
  int                  held_count [tspq_pkg::NumClasses];
  int                  held_total;

  queue_word_t         awaited_words [$];
  int                  mismatches;
  int                  words_seen;
  int                  gap_odds;          // 1-in-N chance of a sender gap, 0 = never
  int                  sink_stall_odds;   // 1-in-N chance of a receiver stall, 0 = never
  int                  sink_stall_left;

  three_class_stable_priority_queue_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_entry_id      (in_entry_id),
    .in_entry_class   (in_entry_class),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_served_id    (out_served_id),
    .out_served_class (out_served_class),
    .out_occupancy    (out_occupancy)
  );

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = tspq_pkg::FUNC_ENQ;
    in_entry_id = '0;
    in_entry_class = '0;
    out_ready = 1'b0;
    held_total = 0;
    mismatches = 0;
    words_seen = 0;
    gap_odds = 0;
    sink_stall_odds = 0;
    sink_stall_left = 0;
    for (int c = 0; c < tspq_pkg::NumClasses; c++) begin
      head_slot[c] = 0;
      tail_slot[c] = 0;
      held_count[c] = 0;
    end
  end

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Next result word of the queue; updates the model state as the core would.
  function automatic queue_word_t predict_queue_op(
      input tspq_pkg::func_t f,
      input logic [tspq_pkg::ID_W-1:0] id,
      input logic [tspq_pkg::CLS_W-1:0] cls);
    queue_word_t w;
    int          k;
    w = '0;
    w.status = tspq_pkg::ST_EMPTY;
    if (f == tspq_pkg::FUNC_ENQ) begin
      // unused class code folds into the lowest class
      k = (cls > tspq_pkg::CLASS_LOW) ? int'(tspq_pkg::CLASS_LOW) : int'(cls);
      if (held_total >= tspq_pkg::Capacity) begin
        w.status = tspq_pkg::ST_FULL;
      end else begin
        held_ids[k][tail_slot[k]] = id;
        tail_slot[k] = (tail_slot[k] == tspq_pkg::Capacity - 1) ? 0 : tail_slot[k] + 1;
        held_count[k]++;
        held_total++;
        w.status = tspq_pkg::ST_ENQUEUED;
      end
    end else begin
      // highest class with anything waiting wins
      for (k = 0; k < tspq_pkg::NumClasses; k++) begin
        if (w.status == tspq_pkg::ST_EMPTY && held_count[k] != 0) begin
          w.id = held_ids[k][head_slot[k]];
          w.cls = tspq_pkg::CLS_W'(k);
          head_slot[k] = (head_slot[k] == tspq_pkg::Capacity - 1) ? 0 : head_slot[k] + 1;
          held_count[k]--;
          held_total--;
          w.status = tspq_pkg::ST_SERVED;
        end
      end
    end
    w.occ = tspq_pkg::OCC_W'(held_total);
    return w;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on word %0d, %s: got %0h, expected %0h", words_seen, field, got, want);
    mismatches++;
  endtask

  // Present one word and hold it until the core takes it. Valid is left high;
  // the caller drops it only when a gap follows.
  task automatic put_word(input tspq_pkg::func_t f, input logic [tspq_pkg::ID_W-1:0] id,
                          input logic [tspq_pkg::CLS_W-1:0] cls, input logic fixed,
                          input queue_word_t want);
    queue_word_t w;
    in_valid <= 1'b1;
    in_func <= f;
    in_entry_id <= id;
    in_entry_class <= cls;
    do @(posedge clk); while (!in_ready);
    w = predict_queue_op(f, id, cls);
    awaited_words.push_back(fixed ? want : w);
  endtask

  // Random sender gap, taken right at the accepting edge.
  task automatic sender_gap();
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Receiver: out_ready drops in random bursts.
  always @(posedge clk) begin
    if (sink_stall_left > 0) begin
      sink_stall_left--;
      out_ready <= 1'b0;
    end else if (sink_stall_odds != 0 && $urandom_range(1, sink_stall_odds) == 1) begin
      sink_stall_left = $urandom_range(0, 9);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Score every word the core hands over against the oldest expectation.
  always @(posedge clk) begin : check_results
    queue_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_words.size() == 0) begin
        report_mismatch("unexpected word, status", 32'(out_status), 32'(0));
      end else begin
        want = awaited_words.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", 32'(out_status), 32'(want.status));
        if (out_served_id !== want.id)
          report_mismatch("served_id", 32'(out_served_id), 32'(want.id));
        if (out_served_class !== want.cls)
          report_mismatch("served_class", 32'(out_served_class), 32'(want.cls));
        if (out_occupancy !== want.occ)
          report_mismatch("occupancy", 32'(out_occupancy), 32'(want.occ));
      end
      words_seen++;
    end
  end

  initial begin : stimulus
    int done;
    int seg_len;
    int enq_pct;
    int pick;
    tspq_pkg::func_t f;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, light idling on both sides
    gap_odds = 4;
    sink_stall_odds = 5;
    foreach (DIRECTED_ROWS[r]) begin
      put_word(DIRECTED_ROWS[r].f, DIRECTED_ROWS[r].id, DIRECTED_ROWS[r].cls,
               DIRECTED_ROWS[r].fixed, DIRECTED_ROWS[r].want);
      sender_gap();
    end

    // random part in segments; the first two fill past full and drain past empty
    done = 0;
    while (done < RANDOM_WORDS) begin
      if (done == 0) begin
        seg_len = tspq_pkg::Capacity + 8;
        enq_pct = 100;
      end else if (done == tspq_pkg::Capacity + 8) begin
        seg_len = tspq_pkg::Capacity + 8;
        enq_pct = 0;
      end else begin
        seg_len = $urandom_range(20, 60);
        pick = $urandom_range(0, 2);
        enq_pct = (pick == 0) ? 15 : (pick == 1) ? 50 : 85;
      end
      if (done >= RANDOM_WORDS - CALM_WORDS) begin
        gap_odds = 0;
        sink_stall_odds = 0;
      end else begin
        pick = $urandom_range(0, 2);
        gap_odds = (pick == 0) ? 0 : (pick == 1) ? 3 : 8;
        pick = $urandom_range(0, 2);
        sink_stall_odds = (pick == 0) ? 0 : (pick == 1) ? 3 : 8;
      end
      for (int i = 0; i < seg_len && done < RANDOM_WORDS; i++) begin
        f = ($urandom_range(1, 100) <= enq_pct) ? tspq_pkg::FUNC_ENQ : tspq_pkg::FUNC_DEQ;
        put_word(f, tspq_pkg::ID_W'($urandom()), tspq_pkg::CLS_W'($urandom_range(0, 3)),
                 1'b0, NO_WORD);
        sender_gap();
        done++;
      end
    end
    in_valid <= 1'b0;

    while (awaited_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== three_class_stable_priority_queue_core.f =====
rtl/tspq_pkg.sv
rtl/tspq_idmem.sv
rtl/three_class_stable_priority_queue_core.sv
bench/tb.sv
